// ----- rtl/core/hbsn_pkg.sv -----
// ----------------------------------------------------------------------------
// hbsn_pkg
// Shared types, codes and the CRC-16/X.25 byte update for the HDLC transmit
// framer (bit stuffing and NRZI line coding).
// ----------------------------------------------------------------------------
package hbsn_pkg;

  // Host command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_FLAG  = 2'd1;
  localparam logic [1:0] CMD_DATA  = 2'd2;
  localparam logic [1:0] CMD_FCS   = 2'd3;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [2:0]  RUN_LIMIT = 3'd5;
  localparam logic [4:0]  BITS_BYTE = 5'd8;
  localparam logic [4:0]  BITS_WORD = 5'd16;

  // Kind of work queued for the serializer
  typedef enum logic [2:0] {
    KIND_START = 3'b001,
    KIND_PLAIN = 3'b010,
    KIND_STUFF = 3'b100
  } kind_t;

  // One queued request, already classified
  typedef struct packed {
    kind_t       kind;
    logic [15:0] bits;
    logic        two_bytes;
  } entry_t;

  // Reflected CRC-16 update over one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ data[i];
      acc = {1'b0, acc[15:1]};
      if (fb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

endpackage

// ----- rtl/core/hbsn_front.sv -----
// ----------------------------------------------------------------------------
// hbsn_front
// Classifies host requests into serializer work and keeps the running FCS.
// ----------------------------------------------------------------------------
module hbsn_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           cmd,
  input  logic [7:0]           data_byte,
  output logic                 ent_valid,
  input  logic                 ent_ready,
  output hbsn_pkg::entry_t     ent
);

  logic [15:0] fcs_acc;
  logic        take;

  assign in_ready  = ent_ready;
  assign ent_valid = in_valid;
  assign take      = in_valid && ent_ready;

  // Build the queue entry for each command
  always_comb begin
    ent.kind      = hbsn_pkg::KIND_START;
    ent.bits      = 16'h0000;
    ent.two_bytes = 1'b0;
    case (cmd)
      hbsn_pkg::CMD_START: begin
        ent.kind = hbsn_pkg::KIND_START;
      end
      hbsn_pkg::CMD_FLAG: begin
        ent.kind = hbsn_pkg::KIND_PLAIN;
        ent.bits = {8'h00, hbsn_pkg::FLAG_BYTE};
      end
      hbsn_pkg::CMD_DATA: begin
        ent.kind = hbsn_pkg::KIND_STUFF;
        ent.bits = {8'h00, data_byte};
      end
      hbsn_pkg::CMD_FCS: begin
        ent.kind      = hbsn_pkg::KIND_STUFF;
        ent.bits      = ~fcs_acc;
        ent.two_bytes = 1'b1;
      end
      default: begin
        ent.kind = hbsn_pkg::KIND_START;
      end
    endcase
  end

  // Reset FCS on flags, advance it on data bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      fcs_acc <= hbsn_pkg::CRC_INIT;
    end else if (take) begin
      if (cmd == hbsn_pkg::CMD_FLAG) begin
        fcs_acc <= hbsn_pkg::CRC_INIT;
      end else if (cmd == hbsn_pkg::CMD_DATA) begin
        fcs_acc <= hbsn_pkg::crc_byte(fcs_acc, data_byte);
      end
    end
  end

endmodule

// ----- rtl/core/hbsn_queue.sv -----
// ----------------------------------------------------------------------------
// hbsn_queue
// Two-entry queue between the classifier and the serializer.
// ----------------------------------------------------------------------------
module hbsn_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  hbsn_pkg::entry_t wr_ent,
  output logic             rd_valid,
  input  logic             rd_ready,
  output hbsn_pkg::entry_t rd_ent
);

  hbsn_pkg::entry_t slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_ent   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_ent;
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/hbsn_back.sv -----
// ----------------------------------------------------------------------------
// hbsn_back
// Serializer: shifts bits out LSB first, inserts stuffed zeros, applies NRZI
// and holds each line bit in an output register.
// ----------------------------------------------------------------------------
module hbsn_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  hbsn_pkg::entry_t q_ent,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic             m_line,
  output logic             m_tlast
);

  logic        act;
  logic [15:0] shreg;
  logic [4:0]  bits_left;
  logic        stuff_pend;
  logic        stuffed;
  logic [2:0]  ones_run;
  logic        line_level;

  logic        act_next;
  logic [15:0] shreg_next;
  logic [4:0]  bits_left_next;
  logic        stuff_pend_next;
  logic        stuffed_next;
  logic [2:0]  ones_run_next;
  logic        line_level_next;

  logic        adv;
  logic        emit;
  logic        bit_val;
  logic        last_now;
  logic        emit_level;

  assign adv     = !m_tvalid || m_tready;
  assign emit    = act && adv;
  assign q_ready = !act || (emit && last_now);

  // Emit one bit, then load the next request when the current one ends
  always_comb begin
    act_next        = act;
    shreg_next      = shreg;
    bits_left_next  = bits_left;
    stuff_pend_next = stuff_pend;
    stuffed_next    = stuffed;
    ones_run_next   = ones_run;
    bit_val         = 1'b1;
    last_now        = 1'b0;
    if (emit) begin
      if (stuff_pend) begin
        bit_val         = 1'b0;
        stuff_pend_next = 1'b0;
        last_now        = (bits_left == 5'd0);
      end else begin
        bit_val        = shreg[0];
        shreg_next     = {1'b0, shreg[15:1]};
        bits_left_next = bits_left - 5'd1;
        if (stuffed) begin
          if (bit_val) begin
            if (ones_run == hbsn_pkg::RUN_LIMIT - 3'd1) begin
              stuff_pend_next = 1'b1;
              ones_run_next   = 3'd0;
            end else begin
              ones_run_next = ones_run + 3'd1;
            end
          end else begin
            ones_run_next = 3'd0;
          end
        end
        last_now = (bits_left == 5'd1) && !stuff_pend_next;
      end
      act_next = !last_now;
    end
    emit_level      = bit_val ? line_level : ~line_level;
    line_level_next = emit ? emit_level : line_level;

    if (q_valid && q_ready) begin
      case (q_ent.kind)
        hbsn_pkg::KIND_START: begin
          line_level_next = 1'b0;
          act_next        = 1'b0;
        end
        hbsn_pkg::KIND_PLAIN: begin
          act_next       = 1'b1;
          shreg_next     = q_ent.bits;
          bits_left_next = hbsn_pkg::BITS_BYTE;
          stuffed_next   = 1'b0;
          ones_run_next  = 3'd0;
        end
        hbsn_pkg::KIND_STUFF: begin
          act_next       = 1'b1;
          shreg_next     = q_ent.bits;
          bits_left_next = q_ent.two_bytes ? hbsn_pkg::BITS_WORD : hbsn_pkg::BITS_BYTE;
          stuffed_next   = 1'b1;
        end
        default: begin
          act_next = 1'b0;
        end
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      act        <= 1'b0;
      bits_left  <= 5'd0;
      stuff_pend <= 1'b0;
      stuffed    <= 1'b0;
      ones_run   <= 3'd0;
      line_level <= 1'b0;
    end else begin
      act        <= act_next;
      bits_left  <= bits_left_next;
      stuff_pend <= stuff_pend_next;
      stuffed    <= stuffed_next;
      ones_run   <= ones_run_next;
      line_level <= line_level_next;
    end
  end

  always_ff @(posedge clk) begin
    shreg <= shreg_next;
  end

  // Output register: refill whenever it is empty or taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_line  <= emit_level;
      m_tlast <= last_now;
    end
  end

`ifndef NO_ASSERTIONS
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    ones_run < hbsn_pkg::RUN_LIMIT)
    else $error("ones run reached the stuffing limit without a stuffed zero");

  a_stuff_active: assert property (@(posedge clk) disable iff (rst)
    stuff_pend |-> (act && stuffed))
    else $error("stuffed zero pending outside a stuffed request");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !act |-> (bits_left == 5'd0) && !stuff_pend)
    else $error("serializer idle with bits left");

  a_stuff_toggle: assert property (@(posedge clk) disable iff (rst)
    (emit && stuff_pend && bits_left != 5'd0) |=> (line_level != $past(line_level)))
    else $error("stuffed zero did not toggle the line");
`endif

endmodule

// ----- rtl/core/hdlc_bit_stuff_nrzi_encoder.sv -----
// ----------------------------------------------------------------------------
// hdlc_bit_stuff_nrzi_encoder
// AX.25 HDLC transmit framer: flags, stuffed data, CRC-16/X.25 FCS, NRZI.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel takes one host request per beat: start line, send flag,
//   send data byte or send FCS. Master channel gives one NRZI line level per
//   beat; tlast marks the final bit of each request. A start request only
//   zeroes the line level and produces no beat.
//   Path: a request passes through the queue, the serializer's working
//   registers and the output register before its first line bit appears.
//   Throughput: one line bit per cycle while tready is high; a flag is 8
//   line bits, a data byte 8 to 10, an FCS 16 to 20 with stuffed zeros, all
//   from the single bit serializer. Back-to-back requests follow without gap,
//   except after a start request, which leaves the serializer idle; a two-entry queue holds requests meanwhile.
//   Reset: line level 0, ones run 0, FCS 0xFFFF, queue and output empty.
//   Stall: when the receiver holds tready low the output bit is held and the
//   serializer waits; requests keep being taken until the queue is full.
// ----------------------------------------------------------------------------
module hdlc_bit_stuff_nrzi_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [1:0] cmd, [9:2] data_byte, [15:10] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] line_bit, [7:1] zero
  output logic        m_tlast
);

  logic             ent_valid;
  logic             ent_ready;
  hbsn_pkg::entry_t ent;
  logic             q_valid;
  logic             q_ready;
  hbsn_pkg::entry_t q_ent;
  logic             m_line;

  // Classify requests and track FCS
  hbsn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .cmd       (s_tdata[1:0]),
    .data_byte (s_tdata[9:2]),
    .ent_valid (ent_valid),
    .ent_ready (ent_ready),
    .ent       (ent)
  );

  // Decouple front from serializer
  hbsn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (ent_valid),
    .wr_ready (ent_ready),
    .wr_ent   (ent),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_ent   (q_ent)
  );

  // Serialize, stuff and encode
  hbsn_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_ent    (q_ent),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_line   (m_line),
    .m_tlast  (m_tlast)
  );

  assign m_tdata = {7'b0000000, m_line};

endmodule
